@@ hw/rtl/hll_pkg.sv @@
`default_nettype none

package hll_pkg;

	localparam int REGISTER_COUNT_DEF = 16384;

	// Widest index and count any legal register count needs
	localparam int IDX_W_MAX = 16;
	localparam int CNT_W_MAX = 17;

	localparam int KIND_W  = 2;
	localparam int HASH_W  = 64;
	localparam int EIDX_W  = 14;
	localparam int RANK_W  = 6;
	localparam int EST_W   = 64;
	localparam int EMPTY_W = 15;
	localparam int THR_W   = 15;
	localparam int LIM_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Fraction bits of the 2^-rank sum
	localparam int SUM_FRAC = 49;

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MERGE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EST   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIN_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_LIM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THR = 2'd2;

	localparam logic [THR_W-1:0] LIN_THR_RST   = 15'd1246;
	localparam logic [LIM_W-1:0] LIN_LIM_RST   = 16'd37000;
	localparam logic [THR_W-1:0] ALPHA_THR_RST = 15'd715;

	// ln 2 and the two alpha values, Q0.32
	localparam logic [31:0] LN2_Q32        = 32'd2977044472;
	localparam logic [31:0] ALPHA_LOW_Q32  = 32'd3023607604;
	localparam logic [31:0] ALPHA_HIGH_Q32 = 32'd3089557045;

	typedef struct packed {
		logic                 vld;
		logic [IDX_W_MAX-1:0] idx;
		logic [RANK_W-1:0]    rank;
	} upd_t;

	typedef struct packed {
		logic [EST_W-1:0]     sum;
		logic [CNT_W_MAX-1:0] empty;
	} walk_t;

	typedef struct packed {
		logic [THR_W-1:0] lin_thr;
		logic [LIM_W-1:0] lin_lim;
		logic [THR_W-1:0] alpha_thr;
	} cfg_t;

	typedef struct packed {
		logic                 vld;
		logic [EST_W-1:0]     est;
		logic [CNT_W_MAX-1:0] empty;
		logic                 lin;
	} res_t;

	// log2 in Q.32 by repeated squaring; used for elaboration constants
	function automatic logic [63:0] log2_q32(input logic [CNT_W_MAX-1:0] x);
		logic [4:0]  n;
		logic [63:0] m;
		logic [31:0] frac;
		n = '0;
		for (int k = 1; k < CNT_W_MAX; k++) begin
			if (x[k]) begin
				n = 5'(k);
			end
		end
		m = (64'(x) << 30) >> n;
		frac = '0;
		for (int i = 0; i < 32; i++) begin
			m = (m * m) >> 30;
			if (m[31]) begin
				m = m >> 1;
				frac[31-i] = 1'b1;
			end
		end
		return {27'd0, n, frac};
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hll_store.sv @@
`default_nettype none

module hll_store import hll_pkg::*; #(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire upd_t  upd,
	input  wire logic  walk_start,
	output logic       rdy,
	output walk_t      walk,
	output logic       walk_done
);

	localparam int IW = $clog2(REGISTER_COUNT);
	localparam int CW = $clog2(REGISTER_COUNT + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(REGISTER_COUNT - 1);

	logic [RANK_W-1:0] mem [REGISTER_COUNT];

	logic              clr_q, walking_q, done_q;
	logic [IW-1:0]     cnt_q;
	logic              rv_s1, last_s1;
	logic              upd_vld_s1;
	logic [IW-1:0]     upd_idx_s1;
	logic [RANK_W-1:0] upd_rank_s1;
	logic [RANK_W-1:0] rdata_s1;
	logic              fw_vld_q;
	logic [IW-1:0]     fw_idx_q;
	logic [RANK_W-1:0] fw_val_q;
	logic [EST_W-1:0]  sum_q;
	logic [CW-1:0]     empty_q;

	logic [RANK_W-1:0] old_rank;
	logic              we_rmw, we;
	logic [IW-1:0]     raddr, waddr;
	logic [RANK_W-1:0] wdata;
	logic [EST_W-1:0]  term;
	logic [EST_W:0]    sum_wide;
	logic              cnt_last;

	// Forward the write of the previous beat; the read port saw the old entry
	assign old_rank = (fw_vld_q && fw_idx_q == upd_idx_s1) ? fw_val_q : rdata_s1;
	assign we_rmw   = upd_vld_s1 && upd_rank_s1 > old_rank;
	assign we       = clr_q || we_rmw;
	assign waddr    = clr_q ? cnt_q : upd_idx_s1;
	assign wdata    = clr_q ? '0 : upd_rank_s1;
	assign raddr    = walking_q ? cnt_q : upd.idx[IW-1:0];
	assign cnt_last = cnt_q == LAST_IDX;

	assign term = (rdata_s1 <= RANK_W'(SUM_FRAC))
		? (EST_W'(1) << (RANK_W'(SUM_FRAC) - rdata_s1)) : '0;
	assign sum_wide = {1'b0, sum_q} + {1'b0, term};

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			walking_q  <= 1'b0;
			cnt_q      <= '0;
			rv_s1      <= 1'b0;
			last_s1    <= 1'b0;
			done_q     <= 1'b0;
			upd_vld_s1 <= 1'b0;
			fw_vld_q   <= 1'b0;
		end else begin
			upd_vld_s1 <= upd.vld;
			fw_vld_q   <= we_rmw;
			rv_s1      <= walking_q;
			last_s1    <= walking_q && cnt_last;
			done_q     <= rv_s1 && last_s1;
			if (clr_q || walking_q) begin
				cnt_q <= cnt_q + IW'(1);
				if (cnt_last) begin
					clr_q     <= 1'b0;
					walking_q <= 1'b0;
					cnt_q     <= '0;
				end
			end else if (walk_start) begin
				walking_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		upd_idx_s1  <= upd.idx[IW-1:0];
		upd_rank_s1 <= upd.rank;
		fw_idx_q    <= upd_idx_s1;
		fw_val_q    <= upd_rank_s1;
		if (walk_start) begin
			sum_q   <= '0;
			empty_q <= '0;
		end else if (rv_s1) begin
			sum_q   <= sum_wide[EST_W] ? '1 : sum_wide[EST_W-1:0];
			empty_q <= empty_q + CW'(rdata_s1 == '0);
		end
	end

	assign rdy        = !clr_q;
	assign walk.sum   = sum_q;
	assign walk.empty = CNT_W_MAX'(empty_q);
	assign walk_done  = done_q;

	a_no_upd_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walking_q |-> !upd.vld) else $error("update during walk");
	a_no_walk_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(walking_q || walk_start || upd.vld)) else $error("activity during clear");
	a_walk_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_start && !clr_q && !walking_q) |=> walking_q) else $error("walk did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !walking_q) else $error("walk done while walking");

endmodule

`default_nettype wire

@@ hw/rtl/hll_estimator.sv @@
`default_nettype none

module hll_estimator import hll_pkg::*; #(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire walk_t walk,
	input  wire cfg_t  cfg,
	input  wire logic  take,
	output res_t       res
);

	localparam int DIV_STEPS = 81;
	localparam int LOG_STEPS = 32;
	localparam logic [CNT_W_MAX-1:0] RC = CNT_W_MAX'(REGISTER_COUNT);
	localparam logic [63:0] LOG2R = log2_q32(RC);
	localparam logic [63:0] R_SQ = 64'(REGISTER_COUNT) * 64'(REGISTER_COUNT);
	localparam logic [63:0] NUM_LOW  = R_SQ * 64'(ALPHA_LOW_Q32);
	localparam logic [63:0] NUM_HIGH = R_SQ * 64'(ALPHA_HIGH_Q32);

	typedef enum logic [8:0] {
		ES_IDLE = 9'b000000001,
		ES_PREP = 9'b000000010,
		ES_LOG  = 9'b000000100,
		ES_LN_A = 9'b000001000,
		ES_LN_B = 9'b000010000,
		ES_LN_C = 9'b000100000,
		ES_LN_D = 9'b001000000,
		ES_DIV  = 9'b010000000,
		ES_DONE = 9'b100000000
	} est_state_t;

	est_state_t state_q;
	logic [6:0] it_q;

	logic [EST_W-1:0]     sum_q, r_q, q_q, est_q;
	logic [CNT_W_MAX-1:0] empty_q;
	logic                 sat_q, lin_q;
	logic [4:0]           n_q;
	logic [30:0]          m_q;
	logic [31:0]          frac_q;
	logic [63:0]          p_lo_q;
	logic [36:0]          p_hi_q;
	logic [37:0]          lnq_q;
	logic [48:0]          m1_q;
	logic [22:0]          m2_q;
	logic [80:0]          nsh_q;

	logic [4:0]       lead;
	logic [30:0]      m_init;
	logic [61:0]      sq;
	logic [31:0]      sq_t;
	logic [63:0]      d;
	logic [23:0]      lin_est;
	logic             lin_try, lin_ok, sum_zero;
	logic [63:0]      num_sel;
	logic [EST_W-1:0] r_sh, r_nx, q_nx;
	logic             ge, sat_nx;

	always_comb begin
		lead = '0;
		for (int k = 1; k < CNT_W_MAX; k++) begin
			if (empty_q[k]) begin
				lead = 5'(k);
			end
		end
	end

	assign m_init  = 31'((48'(empty_q) << 30) >> lead);
	assign sq      = 62'(m_q) * 62'(m_q);
	assign sq_t    = sq[61:30];
	assign d       = LOG2R - {27'd0, n_q, frac_q};
	assign lin_est = 24'(m2_q) + 24'(m1_q[48:32]);
	assign lin_try = empty_q > CNT_W_MAX'(cfg.lin_thr);
	assign lin_ok  = lin_est < 24'(cfg.lin_lim);
	assign sum_zero = sum_q == '0;
	assign num_sel = (empty_q > CNT_W_MAX'(cfg.alpha_thr)) ? NUM_LOW : NUM_HIGH;

	// One restoring step of the divider
	assign r_sh   = {r_q[EST_W-2:0], nsh_q[80]};
	assign ge     = r_q[EST_W-1] || r_sh >= sum_q;
	assign r_nx   = ge ? r_sh - sum_q : r_sh;
	assign q_nx   = {q_q[EST_W-2:0], ge};
	assign sat_nx = sat_q || q_q[EST_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ES_IDLE;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				ES_IDLE: begin
					if (start) begin
						state_q <= ES_PREP;
					end
				end
				ES_PREP: begin
					if (lin_try) begin
						state_q <= ES_LOG;
						it_q    <= 7'(LOG_STEPS - 1);
					end else if (sum_zero) begin
						state_q <= ES_DONE;
					end else begin
						state_q <= ES_DIV;
						it_q    <= 7'(DIV_STEPS - 1);
					end
				end
				ES_LOG: begin
					if (it_q == '0) begin
						state_q <= ES_LN_A;
					end else begin
						it_q <= it_q - 7'd1;
					end
				end
				ES_LN_A: state_q <= ES_LN_B;
				ES_LN_B: state_q <= ES_LN_C;
				ES_LN_C: state_q <= ES_LN_D;
				ES_LN_D: begin
					if (lin_ok || sum_zero) begin
						state_q <= ES_DONE;
					end else begin
						state_q <= ES_DIV;
						it_q    <= 7'(DIV_STEPS - 1);
					end
				end
				ES_DIV: begin
					if (it_q == '0) begin
						state_q <= ES_DONE;
					end else begin
						it_q <= it_q - 7'd1;
					end
				end
				ES_DONE: begin
					if (take) begin
						state_q <= ES_IDLE;
					end
				end
				default: state_q <= ES_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ES_IDLE: begin
				if (start) begin
					sum_q   <= walk.sum;
					empty_q <= walk.empty;
				end
			end
			ES_PREP: begin
				n_q    <= lead;
				m_q    <= m_init;
				frac_q <= '0;
				r_q    <= '0;
				q_q    <= '0;
				sat_q  <= 1'b0;
				nsh_q  <= {num_sel, 17'd0};
				if (!lin_try && sum_zero) begin
					est_q <= '1;
					lin_q <= 1'b0;
				end
			end
			ES_LOG: begin
				m_q    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
				frac_q <= {frac_q[30:0], sq_t[31]};
			end
			ES_LN_A: begin
				p_lo_q <= 64'(d[31:0]) * 64'(LN2_Q32);
				p_hi_q <= 37'(d[36:32]) * 37'(LN2_Q32);
			end
			ES_LN_B: lnq_q <= 38'(p_hi_q) + 38'(p_lo_q[63:32]);
			ES_LN_C: begin
				m1_q <= 49'(RC) * 49'(lnq_q[31:0]);
				m2_q <= 23'(RC) * 23'(lnq_q[37:32]);
			end
			ES_LN_D: begin
				if (lin_ok) begin
					est_q <= 64'(lin_est);
					lin_q <= 1'b1;
				end else if (sum_zero) begin
					est_q <= '1;
					lin_q <= 1'b0;
				end
			end
			ES_DIV: begin
				r_q   <= r_nx;
				q_q   <= q_nx;
				sat_q <= sat_nx;
				nsh_q <= nsh_q << 1;
				if (it_q == '0) begin
					est_q <= sat_nx ? '1 : q_nx;
					lin_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign res.vld   = state_q == ES_DONE;
	assign res.est   = est_q;
	assign res.empty = empty_q;
	assign res.lin   = lin_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ES_IDLE) else $error("walk finished while estimator busy");
	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && !take) |=> res.vld && $stable(est_q)) else $error("result dropped");
	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && res.lin) |-> est_q < 64'(cfg.lin_lim)) else $error("linear result over limit");

endmodule

`default_nettype wire

@@ hw/rtl/hyperloglog_cardinality_sketch.sv @@
// HyperLogLog cardinality sketch.
// Input channel (in_valid/in_ready) carries one beat per operation: kind
// selects add of hash_value, merge of entry_value into entry_index, or an
// estimate request. Add and merge return nothing; the estimate request
// returns one beat on the output channel (out_valid/out_ready) with the
// floored, saturating estimate, the count of empty registers and a flag for
// the linear-counting path.
// Add and merge beats are taken one per clock: each is a read-modify-write
// of the rank memory (one read, one write port) with forwarding of the
// previous write, so back-to-back hits on one entry stay exact.
// An estimate walks the memory one entry per clock, then runs the log unit
// (32 squaring steps, 4 more for the ln scaling) and/or the restoring divider
// (81 steps); the divider is skipped when the sum is zero.
// No input beat is taken from the estimate request until its result moves
// into the output register.
// After reset the memory is cleared one entry per clock and in_ready stays low
// until the clear is done; configuration writes are taken at any time.
// A stalled receiver holds the result in the output register; adds and merges
// keep flowing, and a later estimate waits at its end for the register.
`default_nettype none

module hyperloglog_cardinality_sketch import hll_pkg::*; #(
	parameter int REGISTER_COUNT = REGISTER_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [KIND_W-1:0]    kind,
	input  wire logic [HASH_W-1:0]    hash_value,
	input  wire logic [EIDX_W-1:0]    entry_index,
	input  wire logic [RANK_W-1:0]    entry_value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [EST_W-1:0]          estimate,
	output logic [EMPTY_W-1:0]        empty_count,
	output logic                      used_linear
);

	localparam int IB = $clog2(REGISTER_COUNT);
	localparam logic [CNT_W_MAX-1:0] RC = CNT_W_MAX'(REGISTER_COUNT);

	cfg_t  cfg_q;
	logic  busy_q, out_valid_q;
	logic  [EST_W-1:0]   est_q;
	logic  [EMPTY_W-1:0] empty_q;
	logic  lin_q;

	logic  accept, take, store_rdy, walk_done;
	logic  [IB-1:0]     rev;
	logic  [HASH_W-1:0] tail, run;
	logic  [RANK_W-1:0] add_rank;
	upd_t  upd;
	walk_t walk;
	res_t  res;

	assign in_ready = !busy_q && store_rdy;
	assign accept   = in_valid && in_ready;

	// Index: low hash bits reversed, hash bit 0 lands in the MSB
	always_comb begin
		for (int i = 0; i < IB; i++) begin
			rev[IB-1-i] = hash_value[i];
		end
	end

	// Rank: 1 + run of ones above the index bits (isolate run, then count)
	assign tail     = hash_value >> IB;
	assign run      = tail & ~(tail + HASH_W'(1));
	assign add_rank = RANK_W'($countones(run)) + RANK_W'(1);

	always_comb begin
		upd.vld  = 1'b0;
		upd.idx  = IDX_W_MAX'(rev);
		upd.rank = add_rank;
		if (kind == KIND_MERGE) begin
			upd.idx  = IDX_W_MAX'(entry_index);
			upd.rank = entry_value;
			upd.vld  = accept && (CNT_W_MAX'(entry_index) < RC);
		end else if (kind == KIND_ADD) begin
			upd.vld  = accept && (CNT_W_MAX'(rev) < RC);
		end
	end

	hll_store #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.walk_start(accept && kind == KIND_EST),
		.rdy       (store_rdy),
		.walk      (walk),
		.walk_done (walk_done)
	);

	hll_estimator #(
		.REGISTER_COUNT(REGISTER_COUNT)
	) u_est (
		.clk   (clk),
		.arst_n(arst_n),
		.start (walk_done),
		.walk  (walk),
		.cfg   (cfg_q),
		.take  (take),
		.res   (res)
	);

	// Move the result into the output register once it is free
	assign take = res.vld && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lin_thr   <= LIN_THR_RST;
			cfg_q.lin_lim   <= LIN_LIM_RST;
			cfg_q.alpha_thr <= ALPHA_THR_RST;
			busy_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_LIN_THR:   cfg_q.lin_thr   <= cfg_data[THR_W-1:0];
					CFG_LIN_LIM:   cfg_q.lin_lim   <= cfg_data[LIM_W-1:0];
					CFG_ALPHA_THR: cfg_q.alpha_thr <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (accept && kind == KIND_EST) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			est_q   <= res.est;
			empty_q <= res.empty[EMPTY_W-1:0];
			lin_q   <= res.lin;
		end
	end

	assign out_valid   = out_valid_q;
	assign estimate    = est_q;
	assign empty_count = empty_q;
	assign used_linear = lin_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> busy_q) else $error("result without a pending request");
	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q && !busy_q) else $error("result not moved to output");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !upd.vld) else $error("update during estimate");

endmodule

`default_nettype wire
